// ===== design/telemetry_frame_crc16_defines.svh =====
// shared assertion macros
`ifndef TELEMETRY_FRAME_CRC16_DEFINES_SVH
`define TELEMETRY_FRAME_CRC16_DEFINES_SVH

`ifndef SYNTHESIS

`define TFC_ASSERT(label, c, r, prop) \
  label: assert property (@(posedge c) disable iff (!r) prop) \
    else $error("telemetry_frame_crc16 check failed");

`define TFC_ASSERT_NEVER(label, c, r, cond) \
  label: assert property (@(posedge c) disable iff (!r) !(cond)) \
    else $error("telemetry_frame_crc16 forbidden condition");

`else

`define TFC_ASSERT(label, c, r, prop)

`define TFC_ASSERT_NEVER(label, c, r, cond)

`endif

`endif

// ===== design/tfc_pkg.sv =====
package tfc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned NUM_VALUES  = 4;
  localparam int unsigned WORD_W      = VALUE_W * NUM_VALUES;
  localparam int unsigned DATA_LEN    = WORD_W / BYTE_W;
  localparam int unsigned FRAME_LEN   = DATA_LEN + 2;
  localparam int unsigned IDX_W       = $clog2(FRAME_LEN);
  localparam int unsigned BSEL_W      = $clog2(DATA_LEN);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } queue_head_t;

  // reflected crc-16, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/telemetry_frame_crc16.sv =====
// channel   ports                                              direction
// input     push, full, in_speed, in_motor_drive, in_angle,   in
//           in_extra_value
// result    empty, pop, out_frame_byte, out_last_byte          out
//
// one word in gives ten bytes out: eight value bytes low first, then crc low, crc high
// the serializer puts out one byte per cycle while the output is not stalled, and
// folds each value byte into the crc; the next word loads as the crc high byte leaves
// first byte shows after the queue, word_r, out_byte_r; queue holds QUEUE_DEPTH words
// synchronous active-low reset empties the queue and the output register
// a stalled output holds its byte; the queue keeps taking input until it fills
module telemetry_frame_crc16 #(
  parameter int unsigned QUEUE_DEPTH = tfc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_motor_drive,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_extra_value,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte
);
  import tfc_pkg::*;

  queue_head_t head;
  logic        deq;

  tfc_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_speed      (in_speed),
    .in_motor_drive(in_motor_drive),
    .in_angle      (in_angle),
    .in_extra_value(in_extra_value),
    .head          (head),
    .deq           (deq)
  );

  tfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .deq           (deq),
    .empty         (empty),
    .pop           (pop),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

// ===== design/tfc_front.sv =====
module tfc_front #(
  parameter int unsigned DEPTH = tfc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   in_speed,
  input  logic signed [15:0]   in_motor_drive,
  input  logic signed [15:0]   in_angle,
  input  logic signed [15:0]   in_extra_value,
  output tfc_pkg::queue_head_t head,
  input  logic                 deq
);
  import tfc_pkg::*;

  `include "telemetry_frame_crc16_defines.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] in_word;
  logic              enq;

  // byte k of the frame is in_word[8k +: 8]
  assign in_word = {in_extra_value, in_angle, in_motor_drive, in_speed};

  assign full = (count_r == CNT_W'(DEPTH));
  assign enq  = push && !full;

  assign head.valid = (count_r != '0);
  assign head.word  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({enq, deq})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots_r[wr_ptr_r] <= in_word;
    end
  end

  `TFC_ASSERT_NEVER(a_no_overflow, clk, rst_n, count_r > CNT_W'(DEPTH))
  `TFC_ASSERT(a_count_up, clk, rst_n, (enq && !deq) |=> count_r == $past(count_r) + 1'b1)
  `TFC_ASSERT(a_deq_nonempty, clk, rst_n, deq |-> count_r != '0)

endmodule

// ===== design/tfc_back.sv =====
module tfc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfc_pkg::queue_head_t head,
  output logic                 deq,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_frame_byte,
  output logic                 out_last_byte
);
  import tfc_pkg::*;

  `include "telemetry_frame_crc16_defines.svh"

  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [BYTE_W-1:0] cur_byte;
  logic              adv;
  logic              load;
  logic              mid_step;
  logic              last_step;

  assign adv  = !out_valid_r || pop;
  assign load = adv && head.valid && (!busy_r || idx_r == IDX_LAST);
  assign deq  = load;

  assign mid_step  = adv && busy_r && (idx_r != IDX_LAST);
  assign last_step = adv && busy_r && (idx_r == IDX_LAST);

  always_comb begin
    if (idx_r == IDX_CRC_LO) begin
      cur_byte = crc_r[7:0];
    end else if (idx_r == IDX_LAST) begin
      cur_byte = crc_r[15:8];
    end else begin
      cur_byte = word_r[idx_r[BSEL_W-1:0] * BYTE_W +: BYTE_W];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && !pop;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (adv && busy_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = (idx_r == IDX_LAST);
      if (idx_r < IDX_CRC_LO) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
      idx_nxt = idx_r + 1'b1;
      if (idx_r == IDX_LAST) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      crc_nxt  = CRC_INIT;
      word_nxt = head.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    word_r     <= word_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign empty          = !out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  `TFC_ASSERT_NEVER(a_idx_range, clk, rst_n, idx_r > IDX_LAST)
  `TFC_ASSERT(a_last_flag, clk, rst_n, last_step |=> out_valid_r && out_last_r)
  `TFC_ASSERT(a_idx_step, clk, rst_n, mid_step |=> busy_r && idx_r == $past(idx_r) + 1'b1)

endmodule
